>>> sv/rpy_pkg.sv
// Package: payload types, fixed-point constants and the arctangent table.
package rpy_pkg;

	localparam int AngleWidth   = 16;
	localparam int OutWidth     = 16;
	localparam int CordicStages = 16;
	// Deep enough to cover the credit loop through the CORDIC
	localparam int FifoDepth    = 32;
	localparam int FifoAw       = 5;

	// Internal Q.30 values in 34 bits: CORDIC x/y/z stay well inside.
	localparam int IW = 34;

	localparam logic signed [IW-1:0] PiQ30     = 34'sd3373259426;
	localparam logic signed [IW-1:0] HalfPiQ30 = 34'sd1686629713;
	localparam logic signed [IW-1:0] KinvQ30   = 34'sd652032874;

	typedef struct packed {
		logic signed [AngleWidth-1:0] roll_angle;
		logic signed [AngleWidth-1:0] pitch_angle;
		logic signed [AngleWidth-1:0] yaw_angle;
	} in_item_t;

	typedef struct packed {
		logic signed [OutWidth-1:0] m_row1_col1;
		logic signed [OutWidth-1:0] m_row1_col2;
		logic signed [OutWidth-1:0] m_row1_col3;
		logic signed [OutWidth-1:0] m_row2_col1;
		logic signed [OutWidth-1:0] m_row2_col2;
		logic signed [OutWidth-1:0] m_row2_col3;
		logic signed [OutWidth-1:0] m_row3_col1;
		logic signed [OutWidth-1:0] m_row3_col2;
		logic signed [OutWidth-1:0] m_row3_col3;
	} out_item_t;

	// Sine/cosine triple of one angle plus its reduction flag
	typedef struct packed {
		logic signed [IW-1:0] x;
		logic signed [IW-1:0] y;
		logic signed [IW-1:0] z;
		logic                 flip;
	} cvec_t;

	typedef struct packed {
		logic signed [IW-1:0] sr, cr, sp, cp, sy, cy;
	} trig_t;

	// Queue status between the front and back parts
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic signed [IW-1:0] atan_q30(input int i);
		logic signed [IW-1:0] r;
		case (i)
			0: r = 34'sh3243F6A8; 1: r = 34'sh1DAC6705; 2: r = 34'sh0FADBAFC;
			3: r = 34'sh07F56EA6; 4: r = 34'sh03FEAB76; 5: r = 34'sh01FFD55B;
			6: r = 34'sh00FFFAAA; 7: r = 34'sh007FFF55; 8: r = 34'sh003FFFEA;
			9: r = 34'sh001FFFFD; 10: r = 34'sh000FFFFF; 11: r = 34'sh0007FFFF;
			12: r = 34'sh0003FFFF; 13: r = 34'sh0001FFFF; 14: r = 34'sh0000FFFF;
			15: r = 34'sh00007FFF; 16: r = 34'sh00003FFF; 17: r = 34'sh00001FFF;
			18: r = 34'sh00000FFF; 19: r = 34'sh000007FF; 20: r = 34'sh000003FF;
			21: r = 34'sh000001FF; 22: r = 34'sh000000FF; 23: r = 34'sh0000007F;
			24: r = 34'sh0000003F; 25: r = 34'sh0000001F; 26: r = 34'sh0000000F;
			27: r = 34'sh00000008; 28: r = 34'sh00000004; 29: r = 34'sh00000002;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Q.30 product, rounded half up, arithmetic shift
	function automatic logic signed [IW-1:0] mulq(input logic signed [IW-1:0] a,
		input logic signed [IW-1:0] b);
		logic signed [2*IW-1:0] p;
		p = a * b + (68'sd1 <<< 29);
		return IW'(p >>> 30);
	endfunction

	// Round Q.30 to output format and saturate to +/-1
	function automatic logic signed [OutWidth-1:0] out_el(input logic signed [IW-1:0] v);
		localparam int Sh = 32 - OutWidth;
		logic signed [IW-1:0] r;
		logic signed [IW-1:0] lim;
		lim = IW'(1) <<< (OutWidth - 2);
		r = (v + (IW'(1) <<< (Sh - 1))) >>> Sh;
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return OutWidth'(r);
	endfunction

endpackage

>>> sv/rpy_cordic.sv
// Unrolled, registered rotation-mode CORDIC for the three angles of one item.
module rpy_cordic (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  rpy_pkg::in_item_t in_item,
	output logic             out_valid,
	output rpy_pkg::trig_t   out_trig
);
	import rpy_pkg::*;

	cvec_t v_q [3][CordicStages+1];
	logic  vld_q [CordicStages+1];

	// Angle widening and half-turn reduction
	function automatic cvec_t prep(input logic signed [AngleWidth-1:0] a);
		cvec_t c;
		logic signed [IW-1:0] z;
		z = IW'(a) <<< (33 - AngleWidth);
		c.flip = 1'b0;
		if (z > HalfPiQ30) begin
			z = z - PiQ30; c.flip = 1'b1;
		end else if (z < -HalfPiQ30) begin
			z = z + PiQ30; c.flip = 1'b1;
		end
		c.x = KinvQ30;
		c.y = '0;
		c.z = z;
		return c;
	endfunction

	function automatic cvec_t step(input cvec_t c, input int i);
		cvec_t n;
		n = c;
		if (c.z >= 0) begin
			n.x = c.x - (c.y >>> i);
			n.y = c.y + (c.x >>> i);
			n.z = c.z - atan_q30(i);
		end else begin
			n.x = c.x + (c.y >>> i);
			n.y = c.y - (c.x >>> i);
			n.z = c.z + atan_q30(i);
		end
		return n;
	endfunction

	// Stage 0: reduction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			v_q[0][0] <= prep(in_item.roll_angle);
			v_q[1][0] <= prep(in_item.pitch_angle);
			v_q[2][0] <= prep(in_item.yaw_angle);
		end
	end

	// One micro-rotation per stage
	for (genvar s = 0; s < CordicStages; s++) begin : g_st
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[s+1] <= 1'b0;
			end else if (en) begin
				vld_q[s+1] <= vld_q[s];
			end
		end
		for (genvar k = 0; k < 3; k++) begin : g_ax
			always_ff @(posedge clk) begin
				if (en) v_q[k][s+1] <= step(v_q[k][s], s);
			end
		end
	end

	// Undo reduction sign
	always_comb begin
		cvec_t r, p, y;
		r = v_q[0][CordicStages];
		p = v_q[1][CordicStages];
		y = v_q[2][CordicStages];
		out_trig.sr = r.flip ? -r.y : r.y;
		out_trig.cr = r.flip ? -r.x : r.x;
		out_trig.sp = p.flip ? -p.y : p.y;
		out_trig.cp = p.flip ? -p.x : p.x;
		out_trig.sy = y.flip ? -y.y : y.y;
		out_trig.cy = y.flip ? -y.x : y.x;
	end
	assign out_valid = vld_q[CordicStages];

endmodule

>>> sv/rpy_fifo.sv
// Short queue between the front (CORDIC) and back (matrix) parts.
module rpy_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  rpy_pkg::trig_t  wdata,
	input  logic            rd,
	output rpy_pkg::trig_t  rdata,
	output rpy_pkg::qstat_t stat,
	output logic [rpy_pkg::FifoAw:0] count
);
	import rpy_pkg::*;

	trig_t mem_q [FifoDepth];
	logic [FifoAw-1:0] wp_q, rp_q;
	logic [FifoAw:0]   cnt_q;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (FifoAw+1)'(wr) - (FifoAw+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	assign rdata      = mem_q[rp_q];
	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == (FifoAw+1)'(FifoDepth));
	assign count      = cnt_q;

endmodule

>>> sv/rpy_matrix.sv
// Back part: products, element sums, rounding and output register.
module rpy_matrix (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  rpy_pkg::trig_t    in_trig,
	output logic              in_ready,
	output logic              empty,
	input  logic              pop,
	output rpy_pkg::out_item_t out_item
);
	import rpy_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3;
	trig_t t_s1;
	logic signed [IW-1:0] srsp_s1, crsp_s1;
	logic signed [IW-1:0] p_s2 [13];
	out_item_t o_s3;

	// Pipeline advances when its output stage is free or being taken
	assign en       = !v_s3 || pop;
	assign in_ready = en;
	assign empty    = !v_s3;
	assign out_item = o_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2;
		end
	end

	// Stage 1: roll-pitch partial products
	always_ff @(posedge clk) begin
		if (en) begin
			t_s1    <= in_trig;
			srsp_s1 <= mulq(in_trig.sr, in_trig.sp);
			crsp_s1 <= mulq(in_trig.cr, in_trig.sp);
		end
	end

	// Stage 2: all remaining products, plus the negated pitch sine
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2[0]  <= mulq(t_s1.cy, t_s1.cp);
			p_s2[1]  <= mulq(t_s1.sy, t_s1.cp);
			p_s2[2]  <= -t_s1.sp;
			p_s2[3]  <= mulq(srsp_s1, t_s1.cy);
			p_s2[4]  <= mulq(t_s1.cr, t_s1.sy);
			p_s2[5]  <= mulq(srsp_s1, t_s1.sy);
			p_s2[6]  <= mulq(t_s1.cr, t_s1.cy);
			p_s2[7]  <= mulq(t_s1.sr, t_s1.cp);
			p_s2[8]  <= mulq(crsp_s1, t_s1.cy);
			p_s2[9]  <= mulq(t_s1.sr, t_s1.sy);
			p_s2[10] <= mulq(crsp_s1, t_s1.sy);
			p_s2[11] <= mulq(t_s1.sr, t_s1.cy);
			p_s2[12] <= mulq(t_s1.cr, t_s1.cp);
		end
	end

	// Stage 3: sums, rounding, saturation
	always_ff @(posedge clk) begin
		if (en) begin
			o_s3.m_row1_col1 <= out_el(p_s2[0]);
			o_s3.m_row1_col2 <= out_el(p_s2[1]);
			o_s3.m_row1_col3 <= out_el(p_s2[2]);
			o_s3.m_row2_col1 <= out_el(p_s2[3] - p_s2[4]);
			o_s3.m_row2_col2 <= out_el(p_s2[5] + p_s2[6]);
			o_s3.m_row2_col3 <= out_el(p_s2[7]);
			o_s3.m_row3_col1 <= out_el(p_s2[8] + p_s2[9]);
			o_s3.m_row3_col2 <= out_el(p_s2[10] - p_s2[11]);
			o_s3.m_row3_col3 <= out_el(p_s2[12]);
		end
	end

endmodule

>>> sv/roll_pitch_yaw_rotation_matrix.sv
// Top level: roll-pitch-yaw attitude matrix, CORDIC front, queue, matrix back.
//
//  channel | handshake    | payload
//  input   | push / full  | in  (in_item_t: roll, pitch, yaw)
//  result  | pop / empty  | out (out_item_t: nine Q1.14 elements)
//
// Path: an accepted item passes the 17 CORDIC registers, the first loading at the accepting
// edge, then the queue, then the three matrix stages.
// One item per cycle sustained while results are popped: the queue gives 32 credits.
// full rises when the queue plus the CORDIC stages in flight could overflow it.
// Reset (arst_n) clears valid bits, queue pointers, the queue fill count and the credit count only.
module roll_pitch_yaw_rotation_matrix (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  rpy_pkg::in_item_t  in,
	input  logic               pop,
	output logic               empty,
	output rpy_pkg::out_item_t out
);
	import rpy_pkg::*;

	localparam int CW = $clog2(CordicStages + FifoDepth + 2) + 1;

	logic   acc, cv, bk_ready, qrd;
	trig_t  ct, qd;
	qstat_t qs;
	logic [FifoAw:0] qcnt;
	logic [CW-1:0]   fly_q;

	// Credit: items in CORDIC plus queue may not exceed the queue depth
	assign acc  = push && !full;
	assign full = (fly_q >= CW'(FifoDepth));
	assign qrd  = bk_ready && !qs.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fly_q <= '0;
		else fly_q <= fly_q + CW'(acc) - CW'(qrd);
	end

	rpy_cordic u_front (
		.clk(clk), .arst_n(arst_n), .en(1'b1), .in_valid(acc), .in_item(in),
		.out_valid(cv), .out_trig(ct)
	);

	rpy_fifo u_queue (
		.clk(clk), .arst_n(arst_n), .wr(cv), .wdata(ct), .rd(qrd),
		.rdata(qd), .stat(qs), .count(qcnt)
	);

	rpy_matrix u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(qrd), .in_trig(qd),
		.in_ready(bk_ready), .empty(empty), .pop(pop), .out_item(out)
	);

`ifndef NO_ASSERTIONS
	a_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		cv |-> !qs.full || qrd) else $error("queue overflow");
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(qcnt) <= fly_q) else $error("credit below queue fill");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty) else $error("result lost");
`endif

endmodule

>>> dv/tb_roll_pitch_yaw_rotation_matrix.sv
// Testbench for the roll-pitch-yaw attitude matrix: directed table, random angles, scoreboard.
`timescale 1ns / 1ps

module tb_roll_pitch_yaw_rotation_matrix;
	import rpy_pkg::*;

	localparam int  DirCount   = 16;
	localparam int  RandCount  = 500;
	localparam int  LatCycles  = 40;
	localparam longint CycleLimit = 200000;

	localparam longint PiFix     = 64'sd3373259426;
	localparam longint HalfPiFix = 64'sd1686629713;
	localparam longint KinvFix   = 64'sd652032874;

	// Directed row: angles and an optional typed-in matrix
	typedef struct {
		in_item_t  angles;
		bit        has_known;
		out_item_t known;
	} dir_row_t;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	in_item_t   in;
	logic       pop;
	logic       empty;
	out_item_t  out;

	out_item_t  matrix_q[$];
	int         err_count;
	longint     cycle_count;
	bit         sender_done;
	bit         hold_req;
	int         hold_cycles;
	dir_row_t   dir_rows[DirCount];

	roll_pitch_yaw_rotation_matrix i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.in    (in),
		.pop   (pop),
		.empty (empty),
		.out   (out)
	);

	// Clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Arithmetic shift right, rounding toward minus infinity
	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint fix_mul(longint a, longint b);
		return shr_floor(a * b + (64'sd1 << 29), 30);
	endfunction

	function automatic logic signed [OutWidth-1:0] fix_to_out(longint v);
		longint r;
		longint lim;
		lim = 64'sd1 << (OutWidth - 2);
		r = shr_floor(v + (64'sd1 << (32 - OutWidth - 1)), 32 - OutWidth);
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r[OutWidth-1:0];
	endfunction

	function automatic longint atan_step(int i);
		longint tbl[30] = '{
			64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
			64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
			64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
			64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
			64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
			64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002};
		return tbl[i];
	endfunction

	// Sine and cosine of one Q3.13 angle via reduced rotation CORDIC
	function automatic void angle_trig(input logic signed [AngleWidth-1:0] ang,
		output longint s, output longint c);
		longint z;
		longint x;
		longint y;
		longint nx;
		bit     flip;
		z = longint'(ang) * (64'sd1 << (33 - AngleWidth));
		x = KinvFix;
		y = 0;
		flip = 1'b0;
		if (z > HalfPiFix) begin
			z -= PiFix;
			flip = 1'b1;
		end else if (z < -HalfPiFix) begin
			z += PiFix;
			flip = 1'b1;
		end
		for (int i = 0; i < CordicStages && i < 30; i++) begin
			if (z >= 0) begin
				nx = x - shr_floor(y, i);
				y  = y + shr_floor(x, i);
				z -= atan_step(i);
			end else begin
				nx = x + shr_floor(y, i);
				y  = y - shr_floor(x, i);
				z += atan_step(i);
			end
			x = nx;
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	// Attitude matrix for one angle set
	function automatic out_item_t attitude_matrix(in_item_t a);
		longint sr, cr, sp, cp, sy, cy, srsp, crsp;
		out_item_t m;
		angle_trig(a.roll_angle, sr, cr);
		angle_trig(a.pitch_angle, sp, cp);
		angle_trig(a.yaw_angle, sy, cy);
		srsp = fix_mul(sr, sp);
		crsp = fix_mul(cr, sp);
		m.m_row1_col1 = fix_to_out(fix_mul(cy, cp));
		m.m_row1_col2 = fix_to_out(fix_mul(sy, cp));
		m.m_row1_col3 = fix_to_out(-sp);
		m.m_row2_col1 = fix_to_out(fix_mul(srsp, cy) - fix_mul(cr, sy));
		m.m_row2_col2 = fix_to_out(fix_mul(srsp, sy) + fix_mul(cr, cy));
		m.m_row2_col3 = fix_to_out(fix_mul(sr, cp));
		m.m_row3_col1 = fix_to_out(fix_mul(crsp, cy) + fix_mul(sr, sy));
		m.m_row3_col2 = fix_to_out(fix_mul(crsp, sy) - fix_mul(sr, cy));
		m.m_row3_col3 = fix_to_out(fix_mul(cr, cp));
		return m;
	endfunction

	function automatic logic signed [AngleWidth-1:0] rand_angle();
		int pick;
		pick = $urandom_range(0, 9);
		// Mostly anywhere, sometimes near the half-turn reduction edges or near zero
		case (pick)
			0: return AngleWidth'(12868 + $signed($urandom_range(0, 8)) - 4);
			1: return AngleWidth'(-12868 + $signed($urandom_range(0, 8)) - 4);
			2: return AngleWidth'($signed($urandom_range(0, 8)) - 4);
			default: return AngleWidth'($urandom);
		endcase
	endfunction

	// Send one transfer, waiting for room
	task automatic send_angles(input in_item_t a);
		push <= 1'b1;
		in   <= a;
		do @(posedge clk); while (full);
		matrix_q.push_back(attitude_matrix(a));
	endtask

	task automatic sender_gap();
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("tb_roll_pitch_yaw_rotation_matrix: FAIL");
			$finish;
		end
	end

	// Receiver: random pops, long hold-off on request, compare against oldest expected
	initial begin
		int wait_cyc;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (matrix_q.size() == 0) begin
					$display("%0t: unexpected transfer, actual %p", $realtime, out);
					err_count++;
				end else begin
					out_item_t want;
					want = matrix_q.pop_front();
					if (want !== out) begin
						$display("%0t: mismatch, expected %p, actual %p", $realtime, want, out);
						err_count++;
					end
				end
			end
			if (hold_req) begin
				pop <= 1'b0;
				hold_req = 1'b0;
				repeat (hold_cycles) @(posedge clk);
				pop <= 1'b1;
			end else if (pop && !empty) begin
				wait_cyc = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
				if (wait_cyc > 0) begin
					pop <= 1'b0;
					repeat (wait_cyc) @(posedge clk);
				end
				pop <= 1'b1;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Directed table: extremes, zero, reduction edges
	initial begin
		out_item_t ident;
		ident = '{default: '0};
		ident.m_row1_col1 = 16'sd16384;
		ident.m_row2_col2 = 16'sd16384;
		ident.m_row3_col3 = 16'sd16384;
		dir_rows[0]  = '{'{16'sd0, 16'sd0, 16'sd0}, 1'b1, ident};
		dir_rows[1]  = '{'{-16'sd32768, -16'sd32768, -16'sd32768}, 1'b0, '{default: '0}};
		dir_rows[2]  = '{'{16'sd32767, 16'sd32767, 16'sd32767}, 1'b0, '{default: '0}};
		dir_rows[3]  = '{'{16'sd12868, 16'sd0, 16'sd0}, 1'b0, '{default: '0}};
		dir_rows[4]  = '{'{16'sd12869, 16'sd12867, 16'sd12868}, 1'b0, '{default: '0}};
		dir_rows[5]  = '{'{-16'sd12868, -16'sd12869, -16'sd12867}, 1'b0, '{default: '0}};
		dir_rows[6]  = '{'{16'sd0, 16'sd12868, 16'sd0}, 1'b0, '{default: '0}};
		dir_rows[7]  = '{'{16'sd0, -16'sd12868, 16'sd0}, 1'b0, '{default: '0}};
		dir_rows[8]  = '{'{16'sd25736, 16'sd25736, 16'sd25736}, 1'b0, '{default: '0}};
		dir_rows[9]  = '{'{-16'sd25736, -16'sd25735, -16'sd25737}, 1'b0, '{default: '0}};
		dir_rows[10] = '{'{16'sd1, -16'sd1, 16'sd1}, 1'b0, '{default: '0}};
		dir_rows[11] = '{'{16'sh5555, -16'sh5556, 16'sh2AAA}, 1'b0, '{default: '0}};
		dir_rows[12] = '{'{16'sd6434, 16'sd6434, 16'sd6434}, 1'b0, '{default: '0}};
		dir_rows[13] = '{'{16'sd0, 16'sd0, 16'sd12868}, 1'b0, '{default: '0}};
		dir_rows[14] = '{'{16'sd16384, -16'sd16384, 16'sd8192}, 1'b0, '{default: '0}};
		dir_rows[15] = '{'{-16'sd1, 16'sd0, -16'sd32768}, 1'b0, '{default: '0}};
	end

	// Sender and run control
	initial begin
		push        = 1'b0;
		in          = '0;
		arst_n      = 1'b0;
		err_count   = 0;
		cycle_count = 0;
		sender_done = 1'b0;
		hold_req    = 1'b0;
		hold_cycles = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DirCount; i++) begin
			if (dir_rows[i].has_known &&
					attitude_matrix(dir_rows[i].angles) !== dir_rows[i].known) begin
				$display("%0t: predictor mismatch on row %0d, expected %p, actual %p",
					$realtime, i, dir_rows[i].known, attitude_matrix(dir_rows[i].angles));
				err_count++;
			end
			send_angles(dir_rows[i].angles);
			sender_gap();
		end

		// Drain pause: wait for every expected matrix
		push <= 1'b0;
		while (matrix_q.size() != 0) @(posedge clk);

		// Long receiver hold-off while sending back to back
		hold_cycles = 80;
		hold_req    = 1'b1;
		for (int i = 0; i < 40; i++)
			send_angles('{rand_angle(), rand_angle(), rand_angle()});

		for (int i = 0; i < RandCount; i++) begin
			send_angles('{rand_angle(), rand_angle(), rand_angle()});
			if ($urandom_range(0, 99) < 70) sender_gap();
		end
		push <= 1'b0;
		sender_done = 1'b1;

		while (matrix_q.size() != 0) @(posedge clk);
		repeat (LatCycles) @(posedge clk);
		if (err_count == 0 && matrix_q.size() == 0 && empty) begin
			$display("tb_roll_pitch_yaw_rotation_matrix: PASS");
		end else begin
			$display("tb_roll_pitch_yaw_rotation_matrix: FAIL");
		end
		$finish;
	end

endmodule
